[design/mandelbrot_escape_count_core_macros.svh]
// Assertion helpers for the block's top-level RTL.
`ifndef MANDELBROT_ESCAPE_COUNT_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_CORE_MACROS_SVH

// same-cycle implication
`define MEC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mec assertion failed");

// next-cycle implication
`define MEC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mec assertion failed");

`endif

[design/mec_pkg.sv]
package mec_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 28;
    localparam int LIM_W      = 34;
    localparam int COUNT_BITS = 16;
    localparam int ITER_W     = 16;
    localparam int OUT_W      = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LIM_W-1:0]  LIM_MAX     = {LIM_W{1'b1}};
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 34'd2415919104;
    localparam logic [ITER_W-1:0] ITER_RESET  = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAXIT = 1'd1;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic                  stop;
        logic [COUNT_BITS-1:0] count;
    } t_status;

endpackage

[design/mec_ctrl.sv]
module mec_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  mec_pkg::t_status i_status,
    output mec_pkg::t_cmd   o_cmd,
    output logic            o_in_ready
);
    import mec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MUL;
            S_MUL:  n_state = S_UPD;
            S_UPD:  n_state = i_status.stop ? S_EMIT : S_MUL;
            S_EMIT: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.step  = (r_state == S_UPD) && !i_status.stop;
    assign o_cmd.emit  = (r_state == S_EMIT) && i_out_free;

endmodule

[design/mec_dp.sv]
module mec_dp (
    input  logic                                i_clk,
    input  mec_pkg::t_cmd                       i_cmd,
    input  logic signed [mec_pkg::DATA_W-1:0]   i_c_real,
    input  logic signed [mec_pkg::DATA_W-1:0]   i_c_imag,
    input  logic [mec_pkg::LIM_W-1:0]           i_limit,
    input  logic [mec_pkg::COUNT_BITS-1:0]      i_cap,
    output mec_pkg::t_status                    o_status
);
    import mec_pkg::*;

    logic signed [DATA_W-1:0] r_cr, r_ci, r_re, r_im;
    logic signed [PROD_W-1:0] r_prr, r_pii, r_pri;
    logic [COUNT_BITS-1:0]    r_k;

    logic [PROD_W-1:0]        rr_sh, ii_sh;
    logic [LIM_W-1:0]         re2, im2, mag;
    logic [LIM_W:0]           mag_sum;
    logic signed [PROD_W-1:0] im_sum, re_sum;
    logic signed [DATA_W-1:0] im_new, re_new;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] hi;
        logic signed [DATA_W-1:0] res;
        hi = v[PROD_W-1:DATA_W-1];
        if ((hi == '0) || (hi == '1)) begin
            res = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

    // squares are never negative; shift them down and clamp to the limit width
    assign rr_sh = r_prr >> FRAC_BITS;
    assign ii_sh = r_pii >> FRAC_BITS;
    assign re2   = (|rr_sh[PROD_W-1:LIM_W]) ? LIM_MAX : rr_sh[LIM_W-1:0];
    assign im2   = (|ii_sh[PROD_W-1:LIM_W]) ? LIM_MAX : ii_sh[LIM_W-1:0];

    assign mag_sum = {1'b0, re2} + {1'b0, im2};
    assign mag     = mag_sum[LIM_W] ? LIM_MAX : mag_sum[LIM_W-1:0];

    // 2*re*im: floor shift by one bit less than the fraction; every operand signed
    // so the shift stays arithmetic
    assign im_sum = (r_pri >>> (FRAC_BITS - 1))
                  + $signed({{(PROD_W-DATA_W){r_ci[DATA_W-1]}}, r_ci});
    assign re_sum = $signed({{(PROD_W-LIM_W){1'b0}}, re2})
                  - $signed({{(PROD_W-LIM_W){1'b0}}, im2})
                  + {{(PROD_W-DATA_W){r_cr[DATA_W-1]}}, r_cr};
    assign im_new = sat_data(im_sum);
    assign re_new = sat_data(re_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr <= i_c_real;
            r_ci <= i_c_imag;
            r_re <= '0;
            r_im <= '0;
            r_k  <= '0;
        end else if (i_cmd.step) begin
            r_re <= re_new;
            r_im <= im_new;
            r_k  <= r_k + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prr <= r_re * r_re;
            r_pii <= r_im * r_im;
            r_pri <= r_re * r_im;
        end
    end

    assign o_status.stop  = (r_k >= i_cap) || (mag >= i_limit);
    assign o_status.count = r_k;

endmodule

[design/mandelbrot_escape_count_core.sv]
// Mandelbrot escape-time counter. Each input transfer carries one point c in signed
// Q4.28; the block iterates z = z^2 + c from z = 0 and returns the number of steps
// taken before |z|^2 reached escape_limit_sq or the count reached max_iterations.
// Squares and sums saturate, so overflow always counts as an escape. One point is
// processed at a time: each point passes from input transfer through a loop of a
// multiply state for the three 32x32 multipliers and an update state for the
// saturating update and escape compare, then an emit state that waits for a free
// output register. The finished count sits in an output register, so a new point
// may start while the previous result still waits to be taken.
module mandelbrot_escape_count_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [mec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mec_pkg::LIM_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [2*mec_pkg::DATA_W-1:0]       i_s_tdata,  // [31:0] c_real, [63:32] c_imag
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mec_pkg::OUT_W-1:0]          o_m_tdata   // [15:0] iter_count
);
    import mec_pkg::*;

    logic [LIM_W-1:0]  r_limit;
    logic [ITER_W-1:0] r_max_iter;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              out_free;

    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_max_iter <= ITER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_LIMIT: r_limit    <= i_cfg_wdata;
                CFG_IDX_MAXIT: r_max_iter <= i_cfg_wdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_out_data <= OUT_W'(status.count);
        end
    end

    mec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (o_s_tready)
    );

    mec_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_c_real (i_s_tdata[DATA_W-1:0]),
        .i_c_imag (i_s_tdata[2*DATA_W-1:DATA_W]),
        .i_limit  (r_limit),
        .i_cap    (COUNT_BITS'(r_max_iter)),
        .o_status (status)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`include "mandelbrot_escape_count_core_macros.svh"

    `MEC_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, cmd.emit, !r_out_valid || i_m_tready)
    `MEC_ASSERT_NXT(a_busy_after_load, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    `MEC_ASSERT_NXT(a_emit_shows_valid, i_clk, i_rst_n, cmd.emit, o_m_tvalid)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mec_pkg::*;

    localparam int Q_ONE          = 1 << FRAC_BITS;
    localparam int W_MAX          = 2147483647;
    localparam int W_MIN          = -2147483647 - 1;
    localparam longint MAG_SAT    = 64'h3_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int LONG_HOLD      = 2000;
    localparam int HOLD_EVERY     = 150;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] c_imag;
        logic signed [DATA_W-1:0] c_real;
    } point_t;

    typedef struct {
        point_t           pt;
        logic [OUT_W-1:0] steps;
    } escape_exp_t;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_MOSTLY} sink_mode_t;

    class escape_count_board;
        logic [LIM_W-1:0]  limit_sq = LIMIT_RESET;
        logic [ITER_W-1:0] max_iter = ITER_RESET;
        escape_exp_t       pending_counts[$];
        int                n_errors = 0;
        int                n_checked = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] value);
            case (idx)
                CFG_IDX_LIMIT: limit_sq = value;
                CFG_IDX_MAXIT: max_iter = value[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_w32(longint v);
            if (v > W_MAX) return W_MAX;
            if (v < W_MIN) return W_MIN;
            return v;
        endfunction

        function longint square_q(longint v);
            longint a;
            longint sq;
            a = (v < 0) ? -v : v;
            sq = (a * a) >> FRAC_BITS;
            return (sq > MAG_SAT) ? MAG_SAT : sq;
        endfunction

        // z = z^2 + c from z = 0; new im uses the old re, new re the old squares
        function logic [OUT_W-1:0] escape_steps(point_t p);
            longint cr, ci, re, im, re2, im2, mag, lim, cap, k;
            cr  = longint'(p.c_real);
            ci  = longint'(p.c_imag);
            lim = longint'(limit_sq);
            cap = longint'(max_iter[COUNT_BITS-1:0]);
            re = 0; im = 0; re2 = 0; im2 = 0; mag = 0; k = 0;
            while (k < cap && mag < lim) begin
                im  = clamp_w32(((re * im) >>> (FRAC_BITS - 1)) + ci);
                re  = clamp_w32(re2 - im2 + cr);
                re2 = square_q(re);
                im2 = square_q(im);
                mag = re2 + im2;
                if (mag > MAG_SAT) mag = MAG_SAT;
                k++;
            end
            return k[OUT_W-1:0];
        endfunction

        function void note_point(point_t p);
            escape_exp_t e;
            e.pt    = p;
            e.steps = escape_steps(p);
            pending_counts.push_back(e);
        endfunction

        function int pending();
            return pending_counts.size();
        endfunction

        task report(string msg);
            if (n_errors < 50)
                $display("MISMATCH: %s", msg);
            n_errors++;
        endtask

        task check_count(logic [OUT_W-1:0] got);
            escape_exp_t e;
            n_checked++;
            if (pending_counts.size() == 0) begin
                report($sformatf("iter_count %0d with no point outstanding", got));
            end else begin
                e = pending_counts.pop_front();
                if (got !== e.steps)
                    report($sformatf("c=(%0d,%0d) lim=%0d cap=%0d: iter_count %0d, want %0d",
                                     e.pt.c_real, e.pt.c_imag, limit_sq, max_iter,
                                     got, e.steps));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [LIM_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [2*DATA_W-1:0]    i_s_tdata = '0;   // [31:0] c_real, [63:32] c_imag
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_W-1:0]       o_m_tdata;        // [15:0] iter_count

    escape_count_board board = new();
    point_t            stim[$];

    int corners[8] = '{W_MIN, W_MAX, 0, -1, 1, Q_ONE, -2 * Q_ONE, Q_ONE / 4};
    // points near the set boundary, where escape counts run long
    int rim_re[5]  = '{-201326592, 67108864, -26843546, -335544320, 75161928};
    int rim_im[5]  = '{26843546, 0, 174483046, 5368709, 142270792};

    mandelbrot_escape_count_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic point_t make_point(int re, int im);
        point_t p;
        p.c_real = re;
        p.c_imag = im;
        return p;
    endfunction

    function automatic point_t random_point();
        int sel;
        int k;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return make_point($urandom, $urandom);
            2:    return make_point(corners[$urandom_range(0, 7)], corners[$urandom_range(0, 7)]);
            3, 4: begin
                k = $urandom_range(0, 4);
                return make_point(rim_re[k] + int'($urandom_range(0, 1 << 23)) - (1 << 22),
                                  rim_im[k] + int'($urandom_range(0, 1 << 23)) - (1 << 22));
            end
            // bounding box of the set: re in [-2.25, 0.75], im in [-1.5, 1.5]
            default: return make_point(int'($urandom_range(0, 805306368)) - 603979776,
                                       int'($urandom_range(0, 805306368)) - 402653184);
        endcase
    endfunction

    function automatic void add_random(int n);
        for (int i = 0; i < n; i++)
            stim.push_back(random_point());
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic drive_points();
        int     burst_left;
        int     gap;
        point_t p;
        burst_left = $urandom_range(1, 24);
        while (stim.size() != 0) begin
            p = stim.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= p;
            do @(posedge i_clk); while (!o_s_tready);
            board.note_point(p);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // registers only change with nothing in flight
    task automatic run_phase(logic [LIM_W-1:0] lim, logic [LIM_W-1:0] cap_word, int n_random);
        wait_drained();
        @(posedge i_clk);
        write_reg(CFG_IDX_LIMIT, lim);
        write_reg(CFG_IDX_MAXIT, cap_word);
        add_random(n_random);
        drive_points();
    endtask

    initial begin
        logic [LIM_W-1:0] lim;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: radius 3, cap 500
        stim.push_back(make_point(0, 0));
        stim.push_back(make_point(W_MIN, W_MIN));
        stim.push_back(make_point(W_MAX, W_MAX));
        stim.push_back(make_point(W_MIN, 0));
        stim.push_back(make_point(W_MAX, 0));
        stim.push_back(make_point(0, W_MIN));
        stim.push_back(make_point(0, W_MAX));
        stim.push_back(make_point(W_MAX, W_MIN));
        stim.push_back(make_point(W_MIN, W_MAX));
        stim.push_back(make_point(-2 * Q_ONE, 0));
        stim.push_back(make_point(-2 * Q_ONE - 1, 0));
        stim.push_back(make_point(Q_ONE / 4, 0));
        stim.push_back(make_point(Q_ONE / 4 + (1 << 16), 0));
        stim.push_back(make_point(-Q_ONE, 0));
        stim.push_back(make_point(0, Q_ONE));
        stim.push_back(make_point(-3 * Q_ONE / 4, Q_ONE / 64));
        stim.push_back(make_point(-1, -1));
        stim.push_back(make_point(1, 1));
        add_random(20);
        drive_points();

        run_phase('0, 34'(500), 6);             // zero threshold
        run_phase(LIMIT_RESET, '0, 6);          // zero cap
        run_phase(34'h4000_0000, 34'(64), 300);
        run_phase(LIM_MAX, 34'(40), 100);
        run_phase(34'd1, 34'd1, 30);
        for (int i = 0; i < 5; i++) begin
            lim[31:0]  = $urandom;
            lim[33:32] = $urandom_range(0, 3);
            if ($urandom_range(0, 1))
                lim[33:32] = 2'b00;
            run_phase(lim, 34'($urandom_range(1, 255)), 100);
        end
        // upper write-data bits are dropped for the iteration cap
        run_phase(LIMIT_RESET, 34'h2_A5A5_01F4, 100);

        // widest cap: one point that never escapes, one that escapes at once
        wait_drained();
        stim.push_back(make_point(0, 0));
        stim.push_back(make_point(W_MIN, W_MAX));
        run_phase(34'h4000_0000, LIM_MAX, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        int         hold_left;
        int         mode_left;
        int         next_hold_at;
        sink_mode_t mode;
        logic       ready;
        hold_left    = 0;
        mode_left    = 0;
        next_hold_at = HOLD_EVERY;
        mode         = SINK_OPEN;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                board.check_count(o_m_tdata);
            // long hold-off so the core finishes a point and backs up its input
            if (board.n_checked >= next_hold_at) begin
                hold_left    = LONG_HOLD;
                next_hold_at += HOLD_EVERY;
            end
            if (mode_left == 0) begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                ready = 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:   ready = 1'b1;
                    SINK_COIN:   ready = $urandom_range(0, 1);
                    SINK_SPARSE: ready = ($urandom_range(0, 3) == 0);
                    default:     ready = ($urandom_range(0, 7) != 0);
                endcase
            end
            i_m_tready <= ready;
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
